// ===== sv/wspd_pkg.sv =====
// Shared types and constants for the weather sensor pulse decoder.
// No dependencies; imported by the ALU, the core and the top level.
`default_nettype none

package wspd_pkg;

  // Field widths fixed by the sensor format
  localparam int GAP_W    = 16;
  localparam int TEMP_W   = 9;
  localparam int HUM_W    = 8;
  localparam int WIN_COUNT = 4;
  localparam int CFG_IDX_W = 3;

  // Parameter defaults
  localparam int FRAME_NIBBLES_DEF  = 10;
  localparam int HISTORY_FRAMES_DEF = 3;
  localparam int BUFFER_NIBBLES_DEF = 20;
  localparam int VALID_HOLD_DEF     = 73529;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LOW     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HIGH    = 3'd7;

  // Window slots, in test order
  localparam logic [1:0] WIN_DIVIDER = 2'd0;
  localparam logic [1:0] WIN_ZERO    = 2'd1;
  localparam logic [1:0] WIN_ONE     = 2'd2;
  localparam logic [1:0] WIN_SYNC    = 2'd3;

  // Temperature conversion constants
  localparam logic [11:0] F_OFFSET = 12'd320;   // 32.0 F in tenths
  localparam int          T_OFFSET = 500;       // 50.0 degree offset in tenths
  localparam logic [15:0] MUL_5    = 16'd5;
  localparam logic [15:0] RECIP_9  = 16'd7282;  // ceil(2^16 / 9)
  localparam logic [15:0] RECIP_10 = 16'd6554;  // ceil(2^16 / 10)

  typedef enum logic {
    ALU_WIN,   // lo < a < hi
    ALU_MUL    // a * b
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [GAP_W-1:0] a;
    logic [GAP_W-1:0] b;
    logic [GAP_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [2*GAP_W-1:0] prod;
    logic               hit;
  } alu_rsp_t;

  typedef struct packed {
    logic [WIN_COUNT-1:0][GAP_W-1:0] lo;
    logic [WIN_COUNT-1:0][GAP_W-1:0] hi;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } core_stat_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature_c;
    logic [HUM_W-1:0]  humidity_pct;
    logic              reading_valid;
    logic              frame_accepted;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/wspd_alu.sv =====
// Shared arithmetic unit: window compare or 16x16 multiply.
// Depends on wspd_pkg for the request and response types.
`default_nettype none

module wspd_alu
  import wspd_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  // One compare pair and one multiplier, selected by the opcode
  always_comb begin
    rsp.prod = '0;
    rsp.hit  = 1'b0;
    unique case (req.op)
      ALU_WIN: rsp.hit  = (req.a > req.b) && (req.a < req.c);
      ALU_MUL: rsp.prod = req.a * req.b;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/wspd_core.sv =====
// Decoder sequencer: gap classification, frame assembly, history check
// and temperature conversion on the shared ALU. Depends on wspd_pkg, wspd_alu.
`default_nettype none

module wspd_core
  import wspd_pkg::*;
#(
  parameter int FRAME_NIBBLES  = FRAME_NIBBLES_DEF,
  parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
  parameter int BUFFER_NIBBLES = BUFFER_NIBBLES_DEF,
  parameter int VALID_HOLD     = VALID_HOLD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             in_action,
  input  logic [GAP_W-1:0] in_gap,
  input  cfg_t             cfg,
  input  logic             out_free,
  output core_stat_t       stat,
  output result_t          res
);

  localparam int NIW  = $clog2(BUFFER_NIBBLES);
  localparam int BCW  = NIW + 2;
  localparam int CDW  = $clog2(VALID_HOLD + 1);
  localparam int ROWW = FRAME_NIBBLES * 4;
  localparam logic [NIW-1:0] NIBBLE_CAP = NIW'(BUFFER_NIBBLES - 1);
  localparam logic [NIW-1:0] FRAME_CNT  = NIW'(FRAME_NIBBLES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLS, ST_APPLY, ST_SHIFT, ST_CMP,
    ST_M1, ST_M2, ST_TADJ, ST_M3, ST_FIN, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_SYNC, MODE_ZERO1, MODE_ZERO2, MODE_DATA
  } mode_t;

  typedef enum logic [2:0] {
    GAP_UNKNOWN, GAP_DIVIDER, GAP_ZERO, GAP_ONE, GAP_SYNC
  } gap_t;

  state_t            state;
  mode_t             frame_mode;
  gap_t              gap_type;
  logic [1:0]        win;
  logic [GAP_W-1:0]  gap;
  logic [3:0]        nibble_shift;
  logic [BCW-1:0]    bit_count;
  logic [3:0]        frame_nibbles [BUFFER_NIBBLES];
  logic [ROWW-1:0]   frame_history [HISTORY_FRAMES];
  logic [TEMP_W-1:0] held_temperature;
  logic [HUM_W-1:0]  held_humidity;
  logic [CDW-1:0]    valid_countdown;
  logic              accepted;

  // Temperature datapath registers
  logic              xneg;
  logic [11:0]       absx;
  logic [14:0]       ax5;
  logic [11:0]       q9;
  logic              tneg;
  logic [10:0]       at;
  logic [7:0]        q10;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  wspd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // ALU operand selection per step
  always_comb begin
    alu_req = '{op: ALU_WIN, a: '0, b: '0, c: '0};
    unique case (state)
      ST_CLS: alu_req = '{op: ALU_WIN, a: gap, b: cfg.lo[win], c: cfg.hi[win]};
      ST_M1:  alu_req = '{op: ALU_MUL, a: {4'b0, absx}, b: MUL_5, c: '0};
      ST_M2:  alu_req = '{op: ALU_MUL, a: {1'b0, ax5}, b: RECIP_9, c: '0};
      ST_M3:  alu_req = '{op: ALU_MUL, a: {5'b0, at}, b: RECIP_10, c: '0};
      default: alu_req = '{op: ALU_WIN, a: '0, b: '0, c: '0};
    endcase
  end

  // Bit push: next shift value, count and nibble buffer write
  logic [3:0]     shift_next;
  logic [BCW-1:0] count_next;
  logic           push_ok;
  logic           buf_we;
  logic [NIW-1:0] buf_idx;

  always_comb begin
    push_ok    = bit_count[BCW-1:2] < NIBBLE_CAP;
    shift_next = {nibble_shift[2:0], (gap_type == GAP_ONE)};
    count_next = bit_count + BCW'(1);
    buf_idx    = count_next[BCW-1:2] - NIW'(1);
    buf_we     = (state == ST_APPLY) && (frame_mode == MODE_DATA) &&
                 (gap_type == GAP_ZERO || gap_type == GAP_ONE) &&
                 push_ok && (count_next[1:0] == 2'b00);
  end

  // Frame row from the nibble buffer, lowest nibble first, and the history match
  logic [ROWW-1:0] frame_row;
  logic            hist_match;

  always_comb begin
    frame_row = '0;
    for (int m = 0; m < FRAME_NIBBLES; m++) begin
      if (m < BUFFER_NIBBLES) frame_row[4*m +: 4] = frame_nibbles[NIW'(m)];
    end
    hist_match = 1'b1;
    for (int n = 1; n < HISTORY_FRAMES; n++) begin
      if (frame_history[n] != frame_history[0]) hist_match = 1'b0;
    end
  end

  // Window slot to gap kind
  gap_t win_type;
  always_comb begin
    unique case (win)
      WIN_DIVIDER: win_type = GAP_DIVIDER;
      WIN_ZERO:    win_type = GAP_ZERO;
      WIN_ONE:     win_type = GAP_ONE;
      WIN_SYNC:    win_type = GAP_SYNC;
    endcase
  end

  // Temperature arithmetic between multiplies
  logic [11:0]        f_val;
  logic signed [13:0] q9s;
  logic signed [13:0] t_val;
  logic [10:0]        prod10;
  logic [10:0]        rem;
  logic [8:0]         mag;

  always_comb begin
    f_val  = {frame_nibbles[5], frame_nibbles[4], frame_nibbles[3]};
    q9s    = $signed({2'b00, q9});
    if (xneg) q9s = -q9s;
    t_val  = q9s - 14'(T_OFFSET);
    prod10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
    rem    = at - prod10;
    mag    = {1'b0, q10} + 9'(rem >= 11'd5);
  end

  // Nibble buffer, no reset
  always_ff @(posedge clk) begin
    if (buf_we) frame_nibbles[buf_idx] <= shift_next;
  end

  // Sequencer, mode machine and held results
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_mode       <= MODE_SYNC;
      nibble_shift     <= '0;
      bit_count        <= '0;
      held_temperature <= '0;
      held_humidity    <= '0;
      valid_countdown  <= '0;
      accepted         <= 1'b0;
      win              <= '0;
      gap_type         <= GAP_UNKNOWN;
      for (int n = 0; n < HISTORY_FRAMES; n++) frame_history[n] <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            accepted <= 1'b0;
            gap      <= in_gap;
            win      <= WIN_DIVIDER;
            if (in_action) begin
              if (valid_countdown != '0) valid_countdown <= valid_countdown - CDW'(1);
              state <= ST_DONE;
            end else begin
              state <= ST_CLS;
            end
          end
        end

        // One window per cycle, first hit wins
        ST_CLS: begin
          if (alu_rsp.hit) begin
            gap_type <= win_type;
            state    <= ST_APPLY;
          end else if (win == WIN_SYNC) begin
            gap_type <= GAP_UNKNOWN;
            state    <= ST_APPLY;
          end else begin
            win <= win + 2'd1;
          end
        end

        ST_APPLY: begin
          state <= ST_DONE;
          priority if (gap_type == GAP_UNKNOWN) begin
            frame_mode <= MODE_SYNC; bit_count <= '0; nibble_shift <= '0;
          end else if (gap_type == GAP_DIVIDER) begin
            // dividers are ignored
          end else if (frame_mode == MODE_SYNC) begin
            if (gap_type == GAP_SYNC) frame_mode <= MODE_ZERO1;
            else begin
              bit_count <= '0; nibble_shift <= '0;
            end
          end else if (frame_mode == MODE_ZERO1 || frame_mode == MODE_ZERO2) begin
            if (gap_type == GAP_SYNC && frame_mode == MODE_ZERO1) begin
              // repeated sync
            end else if (gap_type == GAP_ZERO) begin
              frame_mode <= (frame_mode == MODE_ZERO1) ? MODE_ZERO2 : MODE_DATA;
            end else begin
              frame_mode <= MODE_SYNC; bit_count <= '0; nibble_shift <= '0;
            end
          end else begin
            if (gap_type == GAP_SYNC) begin
              if (bit_count[BCW-1:2] == FRAME_CNT) state <= ST_SHIFT;
              else begin
                frame_mode <= MODE_SYNC; bit_count <= '0; nibble_shift <= '0;
              end
            end else if (push_ok) begin
              bit_count    <= count_next;
              nibble_shift <= (count_next[1:0] == 2'b00) ? 4'd0 : shift_next;
            end
          end
        end

        // Age the history and append the new frame
        ST_SHIFT: begin
          for (int n = 0; n < HISTORY_FRAMES - 1; n++)
            frame_history[n] <= frame_history[n + 1];
          frame_history[HISTORY_FRAMES - 1] <= frame_row;
          state <= ST_CMP;
        end

        ST_CMP: begin
          if (hist_match) begin
            held_humidity <= {frame_nibbles[7], frame_nibbles[6]};
            xneg  <= f_val < F_OFFSET;
            absx  <= (f_val < F_OFFSET) ? (F_OFFSET - f_val) : (f_val - F_OFFSET);
            state <= ST_M1;
          end else begin
            frame_mode <= MODE_SYNC; bit_count <= '0; nibble_shift <= '0;
            state      <= ST_DONE;
          end
        end

        ST_M1: begin
          ax5   <= alu_rsp.prod[14:0];
          state <= ST_M2;
        end

        // Truncating divide by 9 via reciprocal
        ST_M2: begin
          q9    <= alu_rsp.prod[27:16];
          state <= ST_TADJ;
        end

        ST_TADJ: begin
          tneg  <= t_val < 0;
          at    <= (t_val < 0) ? 11'(-t_val) : 11'(t_val);
          state <= ST_M3;
        end

        // Truncating divide by 10 via reciprocal
        ST_M3: begin
          q10   <= alu_rsp.prod[23:16];
          state <= ST_FIN;
        end

        ST_FIN: begin
          held_temperature <= tneg ? -mag : mag;
          valid_countdown  <= CDW'(VALID_HOLD);
          accepted         <= 1'b1;
          frame_mode       <= MODE_SYNC;
          bit_count        <= '0;
          nibble_shift     <= '0;
          state            <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.ready     = (state == ST_IDLE);
  assign stat.res_valid = (state == ST_DONE);

  assign res.temperature_c  = held_temperature;
  assign res.humidity_pct   = held_humidity;
  assign res.reading_valid  = (valid_countdown != '0);
  assign res.frame_accepted = accepted;

  // A started item keeps the core busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && stat.ready) |=> !stat.ready)
    else $error("core ready right after start");

  // A confirmed frame always leaves the reading valid
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    (stat.res_valid && res.frame_accepted) |-> res.reading_valid)
    else $error("accepted frame without valid reading");

  // Bits only collect in data mode
  a_bits_clear: assert property (@(posedge clk) disable iff (rst)
    (frame_mode != MODE_DATA) |-> (bit_count == '0 && nibble_shift == '0))
    else $error("bits held outside data mode");

  // Bit count never passes the buffer cap
  a_bit_cap: assert property (@(posedge clk) disable iff (rst)
    bit_count[BCW-1:2] <= NIBBLE_CAP)
    else $error("bit count past cap");

endmodule

`default_nettype wire

// ===== sv/weather_sensor_pulse_decoder_top.sv =====
// Weather sensor pulse decoder: stream channels, configuration registers
// and output register around the core. Depends on wspd_pkg, wspd_core.
//
// Usage:
//   Slave stream: s_tdata carries a measured gap length, s_tuser selects a
//   gap (0) or a validity tick (1). Master stream: one result per input
//   transfer with the held temperature, humidity, validity and a flag that
//   marks a freshly confirmed reading.
//   Path to the output register: a tick goes straight to the handoff; a gap
//   takes window compares on the shared ALU, one per cycle, a mode step and
//   the handoff; a closing sync that confirms a frame adds history shift,
//   compare, three multiplies and rounding. s_tready rises at the edge that
//   loads the output register, so the core takes one item at a time. The
//   output register parts both sides: the core may take the next item while
//   a result waits; if the receiver stalls, the core holds its finished
//   result and s_tready stays low until the register frees. Configuration
//   writes via cfg_we/cfg_index/cfg_wdata, only while idle: a rule for the
//   user, not enforced by the block. Synchronous reset restores the default
//   windows, clears the frame history, the held reading and the countdown.
`default_nettype none

module weather_sensor_pulse_decoder_top
  import wspd_pkg::*;
#(
  parameter int FRAME_NIBBLES  = FRAME_NIBBLES_DEF,
  parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
  parameter int BUFFER_NIBBLES = BUFFER_NIBBLES_DEF,
  parameter int VALID_HOLD     = VALID_HOLD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [15:0] gap_length
  input  logic                 s_tuser,   // [0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [8:0] temperature_c, [16:9] humidity_pct,
                                          // [17] reading_valid, [23:18] zero
  output logic                 m_tuser,   // [0] frame_accepted
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAP_W-1:0]     cfg_wdata
);

  cfg_t       cfg;
  core_stat_t stat;
  result_t    res;
  logic       out_free;
  logic       start;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lo[WIN_DIVIDER] <= 16'd3;
      cfg.hi[WIN_DIVIDER] <= 16'd24;
      cfg.lo[WIN_ZERO]    <= 16'd38;
      cfg.hi[WIN_ZERO]    <= 16'd88;
      cfg.lo[WIN_ONE]     <= 16'd95;
      cfg.hi[WIN_ONE]     <= 16'd159;
      cfg.lo[WIN_SYNC]    <= 16'd209;
      cfg.hi[WIN_SYNC]    <= 16'd301;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIVIDER_LOW:  cfg.lo[WIN_DIVIDER] <= cfg_wdata;
        CFG_DIVIDER_HIGH: cfg.hi[WIN_DIVIDER] <= cfg_wdata;
        CFG_ZERO_LOW:     cfg.lo[WIN_ZERO]    <= cfg_wdata;
        CFG_ZERO_HIGH:    cfg.hi[WIN_ZERO]    <= cfg_wdata;
        CFG_ONE_LOW:      cfg.lo[WIN_ONE]     <= cfg_wdata;
        CFG_ONE_HIGH:     cfg.hi[WIN_ONE]     <= cfg_wdata;
        CFG_SYNC_LOW:     cfg.lo[WIN_SYNC]    <= cfg_wdata;
        CFG_SYNC_HIGH:    cfg.hi[WIN_SYNC]    <= cfg_wdata;
      endcase
    end
  end

  assign s_tready = stat.ready;
  assign start    = s_tvalid && stat.ready;
  assign out_free = !m_tvalid || m_tready;

  wspd_core #(
    .FRAME_NIBBLES  (FRAME_NIBBLES),
    .HISTORY_FRAMES (HISTORY_FRAMES),
    .BUFFER_NIBBLES (BUFFER_NIBBLES),
    .VALID_HOLD     (VALID_HOLD)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_action (s_tuser),
    .in_gap    (s_tdata),
    .cfg       (cfg),
    .out_free  (out_free),
    .stat      (stat),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stat.res_valid) begin
      m_tdata <= {6'b0, res.reading_valid, res.humidity_pct, res.temperature_c};
      m_tuser <= res.frame_accepted;
    end
  end

endmodule

`default_nettype wire
